FILE: rtl/core/pfas_pkg.sv
// ----------------------------------------------------------------------------
// pfas_pkg
// Shared constants, tables and controller/datapath interface types for the
// potential-field steering block.
// ----------------------------------------------------------------------------
package pfas_pkg;

  localparam int FORCE_WIDTH_DEF = 48;

  localparam int CNT_W        = 7;
  localparam int ITER_W       = 4;
  localparam int DIV_STEPS    = 74;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [19:0] PI_Q16       = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;
  localparam logic signed [19:0] CORDIC_K_Q16 = 20'sd39797;

  localparam logic [47:0] MAG_CAP        = 48'h7FFF_FFFF_FFFF;
  // (fx^2 + fy^2) * 10000 < 2^32  <=>  fx^2 + fy^2 < 429497
  localparam logic [21:0] SMALL_SQ_LIMIT = 22'd429497;

  // register reset values
  localparam logic [15:0] MAX_LIN_RST  = 16'd1229;
  localparam logic [15:0] MAX_ANG_RST  = 16'd3277;
  localparam logic [15:0] SAFETY_RST   = 16'd307;
  localparam logic [15:0] INFLUENCE_RST = 16'd1536;
  localparam logic [19:0] ATT_GAIN_RST = 20'd65536;
  localparam logic [19:0] REP_GAIN_RST = 20'd25600;
  localparam logic [15:0] MIN_RANGE_RST = 16'd123;
  localparam logic [15:0] MAX_RANGE_RST = 16'd12288;

  typedef enum logic [3:0] {
    REG_MAX_LIN   = 4'd0,
    REG_MAX_ANG   = 4'd1,
    REG_SAFETY    = 4'd2,
    REG_INFLUENCE = 4'd3,
    REG_ATT_GAIN  = 4'd4,
    REG_REP_GAIN  = 4'd5,
    REG_MIN_RANGE = 4'd6,
    REG_MAX_RANGE = 4'd7
  } cfg_reg_t;

  function automatic logic signed [19:0] atan_q16(input logic [ITER_W-1:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic              load;
    logic              eval;
    logic              mul1;
    logic              mul2;
    logic              mul3;
    logic              div_step;
    logic              rot_init;
    logic              vec_init;
    logic              cordic_step;
    logic              rot_mode;
    logic              rot_fin;
    logic              prod_x;
    logic              add_x;
    logic              prod_y;
    logic              add_y;
    logic              close;
    logic              write;
    logic [ITER_W-1:0] iter;
  } pfas_cmd_t;

  typedef struct packed {
    logic repel;
    logic last;
    logic direct;
    logic out_busy;
  } pfas_sts_t;

endpackage

FILE: rtl/core/pfas_ctrl.sv
// ----------------------------------------------------------------------------
// pfas_ctrl
// Sequencer: walks one beam through evaluation, divider, CORDIC and force
// accumulation, and closes the scan on the last beam.
// ----------------------------------------------------------------------------
module pfas_ctrl
  import pfas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfas_sts_t sts,
  output pfas_cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_EVAL     = 18'h00002,
    S_MUL1     = 18'h00004,
    S_MUL2     = 18'h00008,
    S_MUL3     = 18'h00010,
    S_DIV      = 18'h00020,
    S_ROT_LOAD = 18'h00040,
    S_ROT      = 18'h00080,
    S_ROT_FIN  = 18'h00100,
    S_PROD_X   = 18'h00200,
    S_ADD_X    = 18'h00400,
    S_PROD_Y   = 18'h00800,
    S_ADD_Y    = 18'h01000,
    S_CLOSE    = 18'h02000,
    S_CHECK    = 18'h04000,
    S_VEC_LOAD = 18'h08000,
    S_VEC      = 18'h10000,
    S_WRITE    = 18'h20000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd        = '0;
    cmd.iter   = cnt[ITER_W-1:0];
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.repel)     state_next = S_MUL1;
        else if (sts.last) state_next = S_CLOSE;
        else               state_next = S_IDLE;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_ROT_LOAD;
        else cnt_next = cnt + 1'b1;
      end
      S_ROT_LOAD: begin
        cmd.rot_init = 1'b1;
        state_next   = S_ROT;
      end
      S_ROT: begin
        cmd.cordic_step = 1'b1;
        cmd.rot_mode    = 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = S_ROT_FIN;
        else cnt_next = cnt + 1'b1;
      end
      S_ROT_FIN: begin
        cmd.rot_fin = 1'b1;
        state_next  = S_PROD_X;
      end
      S_PROD_X: begin
        cmd.prod_x = 1'b1;
        state_next = S_ADD_X;
      end
      S_ADD_X: begin
        cmd.add_x  = 1'b1;
        state_next = S_PROD_Y;
      end
      S_PROD_Y: begin
        cmd.prod_y = 1'b1;
        state_next = S_ADD_Y;
      end
      S_ADD_Y: begin
        cmd.add_y  = 1'b1;
        state_next = sts.last ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.direct ? S_WRITE : S_VEC_LOAD;
      end
      S_VEC_LOAD: begin
        cmd.vec_init = 1'b1;
        state_next   = S_VEC;
      end
      S_VEC: begin
        cmd.cordic_step = 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = S_WRITE;
        else cnt_next = cnt + 1'b1;
      end
      S_WRITE: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: rtl/core/pfas_dp.sv
// ----------------------------------------------------------------------------
// pfas_dp
// Datapath: configuration registers, beam latch, multipliers, serial divider,
// shared CORDIC, saturating force sums and the output register.
// ----------------------------------------------------------------------------
module pfas_dp
  import pfas_pkg::*;
#(
  parameter int FORCE_WIDTH = FORCE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic [15:0]        beam_range,
  input  logic               range_finite,
  input  logic signed [15:0] beam_angle,
  input  logic               last_beam,
  input  logic               out_ready,
  input  pfas_cmd_t          cmd,
  output pfas_sts_t          sts,
  output logic               out_valid,
  output logic signed [16:0] linear_velocity,
  output logic signed [16:0] angular_velocity,
  output logic               obstacle_stop
);

  localparam int FW = FORCE_WIDTH;
  localparam int CW = FW + 2;              // CORDIC width, room for growth
  localparam int TW = 50;                  // one force term
  localparam int SW = ((FW > TW) ? FW : TW) + 1;
  localparam logic signed [SW-1:0] FMAX = {{(SW - FW + 1){1'b0}}, {(FW - 1){1'b1}}};
  localparam logic signed [SW-1:0] FMIN = ~FMAX;
  localparam logic signed [FW-1:0] SMALL_BOUND = FW'(656);
  localparam logic signed [CW-1:0] UNIT_POS = CW'(65536);

  function automatic logic signed [FW-1:0] sat_add(input logic signed [FW-1:0] a,
                                                   input logic signed [TW-1:0] b);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > FMAX)      return FMAX[FW-1:0];
    else if (s < FMIN) return FMIN[FW-1:0];
    else               return s[FW-1:0];
  endfunction

  function automatic logic signed [17:0] clamp_unit(input logic signed [CW-1:0] v);
    if (v > UNIT_POS)       return 18'sd65536;
    else if (v < -UNIT_POS) return -18'sd65536;
    else                    return v[17:0];
  endfunction

  // configuration
  logic [15:0] max_lin, max_ang, safety, influence, min_range, max_range;
  logic [19:0] att_gain, rep_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lin   <= MAX_LIN_RST;
      max_ang   <= MAX_ANG_RST;
      safety    <= SAFETY_RST;
      influence <= INFLUENCE_RST;
      att_gain  <= ATT_GAIN_RST;
      rep_gain  <= REP_GAIN_RST;
      min_range <= MIN_RANGE_RST;
      max_range <= MAX_RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LIN:   max_lin   <= cfg_data[15:0];
        REG_MAX_ANG:   max_ang   <= cfg_data[15:0];
        REG_SAFETY:    safety    <= cfg_data[15:0];
        REG_INFLUENCE: influence <= cfg_data[15:0];
        REG_ATT_GAIN:  att_gain  <= cfg_data;
        REG_REP_GAIN:  rep_gain  <= cfg_data;
        REG_MIN_RANGE: min_range <= cfg_data[15:0];
        REG_MAX_RANGE: max_range <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // beam latch
  logic [15:0]        r_q;
  logic               fin_q, last_q;
  logic signed [15:0] ang_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_q    <= beam_range;
      fin_q  <= range_finite;
      ang_q  <= beam_angle;
      last_q <= last_beam;
    end
  end

  // magnitude: g*(D-r)*2^38 / (D*r^3)
  logic [31:0] r2;
  logic [47:0] r3;
  logic [63:0] den;
  logic [35:0] num;
  logic [73:0] divd;
  logic [63:0] rem;
  logic [47:0] quo;
  logic        over;
  logic [64:0] rsh;
  logic        ge;
  logic [47:0] mag;

  assign rsh = {rem, divd[73]};
  assign ge  = (rsh >= {1'b0, den});
  assign mag = over ? MAG_CAP : quo;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      r2  <= 32'(r_q) * 32'(r_q);
      num <= 36'(rep_gain) * 36'(influence - r_q);
    end
    if (cmd.mul2) r3 <= 48'(r2) * 48'(r_q);
    if (cmd.mul3) begin
      den  <= 64'(r3) * 64'(influence);
      divd <= {num, 38'b0};
      rem  <= '0;
      quo  <= '0;
      over <= 1'b0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? 64'(rsh - {1'b0, den}) : rsh[63:0];
      quo  <= {quo[46:0], ge};
      over <= over | quo[46];       // quotient passed the cap, sticky
      divd <= {divd[72:0], 1'b0};
    end
  end

  // shared CORDIC (rotation for cos/sin, vectoring for atan2)
  logic signed [CW-1:0] cx, cy;
  logic signed [19:0]   cz;
  logic                 flip;
  logic signed [19:0]   za;
  logic signed [CW-1:0] dx, dy;
  logic signed [19:0]   at;
  logic                 up;

  logic signed [FW-1:0] fx_sum, fy_sum;

  assign za = {ang_q[15], ang_q, 3'b000};
  assign dx = cy >>> cmd.iter;
  assign dy = cx >>> cmd.iter;
  assign at = atan_q16(cmd.iter);
  assign up = cmd.rot_mode ? (cz >= 0) : (cy < 0);

  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      cx <= CW'(CORDIC_K_Q16);
      cy <= '0;
      if (za > HALF_PI_Q16) begin
        cz   <= za - PI_Q16;
        flip <= 1'b1;
      end else if (za < -HALF_PI_Q16) begin
        cz   <= za + PI_Q16;
        flip <= 1'b1;
      end else begin
        cz   <= za;
        flip <= 1'b0;
      end
    end else if (cmd.vec_init) begin
      if (fx_sum < 0) begin
        cx <= -CW'(fx_sum);
        cy <= -CW'(fy_sum);
        cz <= (fy_sum >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        cx <= CW'(fx_sum);
        cy <= CW'(fy_sum);
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (up) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
  end

  // force terms
  logic signed [17:0] cos_q, sin_q;
  logic signed [66:0] prod;
  logic signed [48:0] mag_s;
  logic signed [66:0] prod_sh;
  logic signed [TW-1:0] term;

  assign mag_s   = $signed({1'b0, mag});
  assign prod_sh = prod >>> 16;
  assign term    = -prod_sh[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rot_fin) begin
      cos_q <= clamp_unit(flip ? -cx : cx);
      sin_q <= clamp_unit(flip ? -cy : cy);
    end
    if (cmd.prod_x)      prod <= mag_s * cos_q;
    else if (cmd.prod_y) prod <= mag_s * sin_q;
  end

  // sums and nearest distance
  logic [15:0] nearest;
  logic        repel;

  assign repel = fin_q && (r_q >= min_range) && (r_q <= max_range)
                 && (r_q != 16'd0) && (r_q <= influence);

  always_ff @(posedge clk) begin
    if (rst) begin
      fx_sum  <= '0;
      fy_sum  <= '0;
      nearest <= MAX_RANGE_RST;
    end else begin
      if (cmd.eval && fin_q && (r_q > min_range) && (r_q < nearest)) nearest <= r_q;
      if (cmd.add_x) fx_sum <= sat_add(fx_sum, term);
      if (cmd.add_y) fy_sum <= sat_add(fy_sum, term);
      if (cmd.close) fx_sum <= sat_add(fx_sum, TW'($signed({1'b0, att_gain})));
      if (cmd.write) begin
        fx_sum  <= '0;
        fy_sum  <= '0;
        nearest <= max_range;
      end
    end
  end

  // scan result
  logic [15:0]          near_eff;
  logic                 stop;
  logic signed [10:0]   fxl, fyl;
  logic signed [21:0]   sqx, sqy;
  logic [21:0]          sq;
  logic                 tiny_force;
  logic                 rev;
  logic signed [FW-1:0] fsh, lin_lim;
  logic signed [16:0]   lin;
  logic signed [19:0]   zsh, ang_lim;
  logic signed [16:0]   angc, angv;

  assign near_eff   = (nearest < max_range) ? nearest : max_range;
  assign stop       = (near_eff < safety);
  assign fxl        = fx_sum[10:0];
  assign fyl        = fy_sum[10:0];
  assign sqx        = fxl * fxl;
  assign sqy        = fyl * fyl;
  assign sq         = 22'(sqx) + 22'(sqy);
  assign tiny_force = (fx_sum > -SMALL_BOUND) && (fx_sum < SMALL_BOUND)
                      && (fy_sum > -SMALL_BOUND) && (fy_sum < SMALL_BOUND)
                      && (sq < SMALL_SQ_LIMIT);
  assign rev        = (fx_sum < 0) && (max_lin != 16'd0);

  assign fsh     = fx_sum >>> 4;
  assign lin_lim = FW'($signed({1'b0, max_lin}));
  always_comb begin
    if (fsh > lin_lim)       lin = lin_lim[16:0];
    else if (fsh < -lin_lim) lin = 17'(-lin_lim);
    else                     lin = fsh[16:0];
  end

  assign zsh     = cz >>> 3;
  assign ang_lim = 20'($signed({1'b0, max_ang}));
  always_comb begin
    if (zsh > ang_lim)       angc = ang_lim[16:0];
    else if (zsh < -ang_lim) angc = 17'(-ang_lim);
    else                     angc = zsh[16:0];
    angv = rev ? -angc : angc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      obstacle_stop <= stop;
      if (stop || tiny_force) begin
        linear_velocity  <= '0;
        angular_velocity <= '0;
      end else begin
        linear_velocity  <= lin;
        angular_velocity <= angv;
      end
    end
  end

  assign sts.repel    = repel;
  assign sts.last     = last_q;
  assign sts.direct   = stop || tiny_force;
  assign sts.out_busy = out_valid && !out_ready;

endmodule

FILE: rtl/core/potential_field_avoidance_steer.sv
// ----------------------------------------------------------------------------
// potential_field_avoidance_steer
// Potential-field obstacle avoidance: one laser beam in, one velocity
// command out at the end of each scan.
// ----------------------------------------------------------------------------
// A beam that gives no repulsion is only evaluated. A beam inside the influence
// distance is held mostly by the bit-serial divider that forms the repulsive
// magnitude (74 steps) and by the 16-step CORDIC rotation for cos/sin. The
// last beam of a scan adds the attractive term, plus the CORDIC atan2 when a
// velocity is computed, then the result goes to the output register once it is
// free; the next beam is taken while that result waits.
// ----------------------------------------------------------------------------
module potential_field_avoidance_steer
  import pfas_pkg::*;
#(
  parameter int FORCE_WIDTH = FORCE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        beam_range,
  input  logic               range_finite,
  input  logic signed [15:0] beam_angle,
  input  logic               last_beam,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] linear_velocity,
  output logic signed [16:0] angular_velocity,
  output logic               obstacle_stop
);

  pfas_cmd_t cmd;
  pfas_sts_t sts;

  pfas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfas_dp #(
    .FORCE_WIDTH (FORCE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .beam_range       (beam_range),
    .range_finite     (range_finite),
    .beam_angle       (beam_angle),
    .last_beam        (last_beam),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .obstacle_stop    (obstacle_stop)
  );

endmodule

FILE: rtl/core/pfas_chk.sv
// ----------------------------------------------------------------------------
// pfas_chk
// Port-level checks for the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module pfas_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] linear_velocity,
  input logic signed [16:0] angular_velocity,
  input logic               obstacle_stop
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(linear_velocity)
      && $stable(angular_velocity) && $stable(obstacle_stop))
    else $error("result changed while stalled");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle_stop |-> linear_velocity == 17'sd0 && angular_velocity == 17'sd0)
    else $error("stop with nonzero velocity");

  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angular_velocity != -17'sd65536 && linear_velocity != -17'sd65536)
    else $error("velocity outside clamp range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind potential_field_avoidance_steer pfas_chk u_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .linear_velocity  (linear_velocity),
  .angular_velocity (angular_velocity),
  .obstacle_stop    (obstacle_stop)
);

FILE: bench/potential_field_avoidance_steer_chk.sv
// ----------------------------------------------------------------------------
// potential_field_avoidance_steer_chk
// Checker for the steering block. It tracks register writes, predicts the
// force sums and nearest distance for every beam transfer, queues the
// velocity command expected at each scan end and compares output transfers.
// ----------------------------------------------------------------------------
module potential_field_avoidance_steer_chk
  import pfas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        beam_range,
  input  logic               range_finite,
  input  logic signed [15:0] beam_angle,
  input  logic               last_beam,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [16:0] linear_velocity,
  input  logic signed [16:0] angular_velocity,
  input  logic               obstacle_stop,
  output int                 errors,
  output int                 pending,
  output int                 results,
  output int                 stops
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FORCE_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FORCE_LO = -FORCE_HI - 1;

  typedef struct {
    logic [16:0] lin;
    logic [16:0] ang;
    logic        stop;
  } steer_cmd_t;

  steer_cmd_t cmd_q[$];

  logic [15:0] lin_lim, ang_lim, safe_dist, infl_dist, lo_range, hi_range;
  logic [19:0] att_gain, rep_gain;
  longint      force_x, force_y;
  logic [15:0] nearest;

  longint atan_lut[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint sat_force(longint a, longint b);
    longint s;
    s = a + b;
    if (s > FORCE_HI) return FORCE_HI;
    if (s < FORCE_LO) return FORCE_LO;
    return s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic sin_cos(input longint z_in, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    x = CORDIC_K_Q16;
    y = 0;
    z = z_in;
    flip = 0;
    if (z > HALF_PI_Q16) begin
      z -= PI_Q16;
      flip = 1;
    end else if (z < -HALF_PI_Q16) begin
      z += PI_Q16;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, 65536);
    s = clip(y, 65536);
  endtask

  function automatic longint heading(longint fy, longint fx);
    longint x, y, z, dx, dy;
    x = fx;
    y = fy;
    z = 0;
    if (x < 0) begin
      z = (fy >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  task automatic add_repulsion(input logic [15:0] r, input logic signed [15:0] ang);
    logic [127:0] num, den, q;
    longint       mag, c, s;
    if (r == 0 || r > infl_dist) return;
    num = (128'(rep_gain) * 128'(infl_dist - r)) << 38;
    den = 128'(infl_dist) * 128'(r) * 128'(r) * 128'(r);
    q = num / den;
    mag = (q > 128'(MAG_CAP)) ? longint'(MAG_CAP) : longint'(q);
    sin_cos(longint'(ang) * 8, c, s);
    force_x = sat_force(force_x, -((mag * c) >>> 16));
    force_y = sat_force(force_y, -((mag * s) >>> 16));
  endtask

  task automatic beam_step(input logic [15:0] r, input logic fin,
                           input logic signed [15:0] ang, input logic last);
    steer_cmd_t cmd;
    logic [15:0] near;
    longint      fx, fy, lin, av;
    bit          tiny_force, rev;
    if (fin) begin
      if (r > lo_range && r < nearest) nearest = r;
      if (r >= lo_range && r <= hi_range) add_repulsion(r, ang);
    end
    if (!last) return;
    force_x = sat_force(force_x, longint'(att_gain));
    fx = force_x;
    fy = force_y;
    near = (nearest < hi_range) ? nearest : hi_range;
    lin = 0;
    av = 0;
    cmd.stop = 0;
    if (near < safe_dist) begin
      cmd.stop = 1;
    end else begin
      tiny_force = 0;
      if (fx > -656 && fx < 656 && fy > -656 && fy < 656)
        tiny_force = (fx * fx + fy * fy) * 10000 < 64'sd4294967296;
      if (!tiny_force) begin
        rev = fx < 0 && lin_lim > 0;
        lin = clip(fx >>> 4, longint'(lin_lim));
        av = clip(heading(fy, fx) >>> 3, longint'(ang_lim));
        if (rev) av = -av;
      end
    end
    cmd.lin = lin[16:0];
    cmd.ang = av[16:0];
    cmd_q.push_back(cmd);
    force_x = 0;
    force_y = 0;
    nearest = hi_range;
  endtask

  always @(posedge clk) begin
    steer_cmd_t exp_cmd;
    if (rst) begin
      lin_lim   <= MAX_LIN_RST;
      ang_lim   <= MAX_ANG_RST;
      safe_dist <= SAFETY_RST;
      infl_dist <= INFLUENCE_RST;
      att_gain  <= ATT_GAIN_RST;
      rep_gain  <= REP_GAIN_RST;
      lo_range  <= MIN_RANGE_RST;
      hi_range  <= MAX_RANGE_RST;
      force_x   = 0;
      force_y   = 0;
      nearest   = MAX_RANGE_RST;
      cmd_q.delete();
      errors    <= 0;
      results   <= 0;
      stops     <= 0;
    end else begin
      if (in_valid && in_ready)
        beam_step(beam_range, range_finite, beam_angle, last_beam);
      if (out_valid && out_ready) begin
        results <= results + 1;
        if (cmd_q.size() == 0) begin
          $error("unexpected command transfer: lin %0d ang %0d stop %0b",
                 linear_velocity, angular_velocity, obstacle_stop);
          errors <= errors + 1;
        end else begin
          exp_cmd = cmd_q.pop_front();
          if (exp_cmd.stop) stops <= stops + 1;
          if (linear_velocity !== exp_cmd.lin || angular_velocity !== exp_cmd.ang ||
              obstacle_stop !== exp_cmd.stop) begin
            errors <= errors + 1;
            if (linear_velocity !== exp_cmd.lin)
              $error("linear_velocity: expected %0d, got %0d",
                     $signed(exp_cmd.lin), linear_velocity);
            if (angular_velocity !== exp_cmd.ang)
              $error("angular_velocity: expected %0d, got %0d",
                     $signed(exp_cmd.ang), angular_velocity);
            if (obstacle_stop !== exp_cmd.stop)
              $error("obstacle_stop: expected %0b, got %0b", exp_cmd.stop, obstacle_stop);
          end
        end
      end
      // register writes land after this edge's beam is evaluated
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_LIN:   lin_lim   <= cfg_data[15:0];
          REG_MAX_ANG:   ang_lim   <= cfg_data[15:0];
          REG_SAFETY:    safe_dist <= cfg_data[15:0];
          REG_INFLUENCE: infl_dist <= cfg_data[15:0];
          REG_ATT_GAIN:  att_gain  <= cfg_data;
          REG_REP_GAIN:  rep_gain  <= cfg_data;
          REG_MIN_RANGE: lo_range  <= cfg_data[15:0];
          REG_MAX_RANGE: hi_range  <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    pending <= cmd_q.size();
  end

endmodule

FILE: bench/potential_field_avoidance_steer_tb.sv
// ----------------------------------------------------------------------------
// potential_field_avoidance_steer_tb
// Drives laser scans into the steering block under several register settings
// and idle patterns; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
module potential_field_avoidance_steer_tb;
  import pfas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [3:0]         cfg_index = '0;
  logic [19:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [15:0]        beam_range = '0;
  logic               range_finite = 0;
  logic signed [15:0] beam_angle = '0;
  logic               last_beam = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [16:0] linear_velocity, angular_velocity;
  logic               obstacle_stop;
  int                 errors, pending, results, stops;

  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_off = 0;
  int          beams_sent = 0;
  int          quiet_cycles = 0;
  logic [15:0] infl_now = INFLUENCE_RST;
  logic [15:0] lo_now = MIN_RANGE_RST;

  always #5 clk = ~clk;

  potential_field_avoidance_steer i_dut (.*);

  potential_field_avoidance_steer_chk i_chk (.*);

  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT && !rst) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("** potential_field_avoidance_steer: FAILED **");
      $finish;
    end
  end

  task automatic send_beam(input logic [15:0] r, input logic fin,
                           input logic signed [15:0] ang, input logic last);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid     <= 1;
    beam_range   <= r;
    range_finite <= fin;
    beam_angle   <= ang;
    last_beam    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beams_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [19:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_INFLUENCE) infl_now = val[15:0];
    if (idx == REG_MIN_RANGE) lo_now = val[15:0];
  endtask

  // wait out queued commands and any beam still in the repulsion datapath
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] lin, ang, safe, infl,
                           input logic [19:0] att, rep,
                           input logic [15:0] lo, hi);
    // upper data bits set on 16-bit registers must be dropped
    write_reg(REG_MAX_LIN, {4'hA, lin});
    write_reg(REG_MAX_ANG, {4'h5, ang});
    write_reg(REG_SAFETY, {4'hF, safe});
    write_reg(REG_INFLUENCE, infl);
    write_reg(REG_ATT_GAIN, att);
    write_reg(REG_REP_GAIN, rep);
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
    cfg_we    <= 1;
    cfg_index <= 4'd9 + 4'($urandom_range(6));  // unmapped index, no effect
    cfg_data  <= 20'hFFFFF;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] pick_range();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 16'($urandom_range(infl_now, lo_now));
    if (sel < 70) return 16'd0;
    if (sel < 80) return 16'($urandom_range(lo_now + 2, (lo_now > 1) ? lo_now - 1 : 0));
    return 16'($urandom_range(65535));
  endfunction

  task automatic run_scans(input int n_beams, input int max_len);
    int len, k;
    k = 0;
    while (k < n_beams) begin
      len = $urandom_range(max_len, 1);
      for (int j = 0; j < len && k < n_beams; j++) begin
        // stray beams and cut-off scans are the noise part
        send_beam(pick_range(), $urandom_range(99) < 90,
                  16'($signed($urandom_range(51472)) - 25736),
                  (j == len - 1) || ($urandom_range(99) < 3));
        k++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed beams under reset settings
    send_beam(16'd0, 1, 16'sd0, 0);
    send_beam(16'd5000, 0, 16'sd0, 1);
    send_beam(16'd123, 1, 16'sd25736, 0);
    send_beam(16'd1536, 1, -16'sd25736, 0);
    send_beam(16'd12288, 1, 16'sd12868, 1);
    send_beam(16'd400, 1, 16'sd0, 1);
    send_beam(16'd200, 1, -16'sd12868, 1);
    send_beam(16'd65535, 1, 16'sd100, 1);
    send_beam(16'd124, 1, 16'sd12869, 0);
    send_beam(16'd1000, 1, -16'sd12869, 0);
    send_beam(16'd1535, 0, 16'sd6000, 1);
    send_beam(16'd700, 1, 16'sd20000, 0);
    send_beam(16'd900, 1, -16'sd20000, 1);
    send_beam(16'd122, 1, 16'sd0, 1);
    drain();
    load_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 16'd0, 16'hFFFF);
    send_beam(16'd1, 1, 16'sd0, 0);
    send_beam(16'd1, 1, 16'sd12868, 0);
    send_beam(16'hFFFF, 1, -16'sd25736, 1);
    send_beam(16'd30000, 1, 16'sd25736, 1);
    send_beam(16'd0, 1, 16'sd0, 1);
    drain();
    load_regs(16'd0, 16'd0, 16'd0, 16'd1, 20'd0, 20'd0, 16'd0, 16'd0);
    send_beam(16'd1, 1, 16'sd0, 1);
    send_beam(16'd0, 1, -16'sd100, 1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 73; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 73; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      if (ph == 0)
        load_regs(MAX_LIN_RST, MAX_ANG_RST, SAFETY_RST, INFLUENCE_RST,
                  ATT_GAIN_RST, REP_GAIN_RST, MIN_RANGE_RST, MAX_RANGE_RST);
      else if (ph == 6)
        load_regs(16'd0, 16'hFFFF, 16'd50, 16'd3000, 20'd1000, 20'hFFFFF, 16'd10, 16'd20000);
      else
        load_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(400)), 16'($urandom_range(4000, 100)),
                  20'($urandom_range(1048575)), 20'($urandom_range(200000)),
                  16'($urandom_range(150)), 16'($urandom_range(65535, 2000)));
      if (ph == 4) begin
        // long receiver hold-off with short scans so the block backs up
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
          run_scans(20, 1);
        join
      end
      run_scans(38, 8);
      drain();
    end

    $display("beams sent: %0d, commands checked: %0d (%0d stops)",
             beams_sent, results, stops);
    $display("12 register settings incl. extremes, four idle patterns, one hold-off");
    if (errors == 0) begin
      $display("** potential_field_avoidance_steer: PASSED **");
    end else begin
      $display("** potential_field_avoidance_steer: FAILED **");
    end
    $finish;
  end

endmodule
